// File: design/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent in the next cycle, ignored while reset is asserted.
`define CAE_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

// Consequent in the next cycle, checked during reset as well.
`define CAE_ASSERT_NEXT_ALWAYS(label, clk, cond, conseq, msg) \
    label: assert property (@(posedge clk) (cond) |=> (conseq)) else $error(msg);

`endif

// File: design/cae_pkg.sv
// Types, constants and the divide-by-five helper of the cross average filter.
// Depends on nothing; used by every module of the block.
package cae_pkg;

    localparam int CFG_DATA_W = 11;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH       = 2'd0,
        CFG_IMAGE_HEIGHT      = 2'd1,
        CFG_CHANNEL_THRESHOLD = 2'd2,
        CFG_SUM_THRESHOLD     = 2'd3
    } cfg_index_t;

    localparam logic [7:0] CH_THR_RESET  = 8'd25;
    localparam logic [9:0] SUM_THR_RESET = 10'd50;

    localparam logic ACTION_PIXEL = 1'b0;
    localparam logic ACTION_DRAIN = 1'b1;

    // channel 0 red, 1 green, 2 blue, 3 alpha
    typedef logic [3:0][7:0] pixel_t;

    typedef struct packed {
        logic       action;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } s_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       frame_done;
    } m_item_t;

    typedef struct packed {
        pixel_t center;
        pixel_t left;
        pixel_t right;
        pixel_t top;
        pixel_t bottom;
        logic   has_left;
        logic   has_right;
        logic   has_top;
        logic   has_bottom;
        logic   frame_done;
    } win_t;

    localparam logic [10:0] DIV5_MUL   = 11'd1639;
    localparam int          DIV5_SHIFT = 13;

    // floor(s / 5) for s up to 1275
    function automatic logic [7:0] div5(input logic [10:0] s);
        logic [21:0] p;
        p = 22'(s) * 22'(DIV5_MUL);
        return p[DIV5_SHIFT +: 8];
    endfunction

endpackage

// File: design/cross_average_edge_antialias.sv
// Five-point cross average filter with threshold: configuration registers and top level.
// Depends on cae_pkg, cae_window and cae_filter.
//
// Usage: RGBA pixels enter on s_ in raster order with action = pixel; results leave
// on m_, at most one result per transaction. Each result is the pixel one line plus one
// pixel back, replaced by its floor cross average when a channel or the summed RGB
// difference exceeds its threshold. Once the frame is in, drain transactions each
// give one pending pixel; the last one carries frame_done.
// Configuration goes through cfg_ while the block is idle; writing the width or
// height restarts the frame. cfg_ready is always high.
// A transaction that yields a result passes through the window register and then the
// result register on its way to m_. Throughput: one transaction per cycle while m_ is
// not stalled, set by the read-first line memories that give the right and top taps
// each cycle. A one-row frame pads once after its last pixel, with s_ready low.
// Reset clears counters, valid flags and registers to width 1024, height 1024,
// thresholds 25 and 50; line memories stay uninitialized.
// When m_ready is low the result register and the window register hold, and s_ready
// drops once a window is waiting behind the held result.
module cross_average_edge_antialias import cae_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  s_item_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output m_item_t               m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam logic [WW-1:0] W_RESET = WW'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
    localparam logic [HW-1:0] H_RESET = HW'(MAX_HEIGHT < 1024 ? MAX_HEIGHT : 1024);

    logic [WW-1:0] width_reg, width_next;
    logic [HW-1:0] height_reg, height_next;
    logic [7:0]    ch_thr_reg, ch_thr_next;
    logic [9:0]    sum_thr_reg, sum_thr_next;
    logic          cfg_wr, restart;
    logic          win_valid, win_ready;
    win_t          win;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb begin
        width_next   = width_reg;
        height_next  = height_reg;
        ch_thr_next  = ch_thr_reg;
        sum_thr_next = sum_thr_reg;
        restart      = 1'b0;
        if (cfg_wr) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH: begin
                    restart = 1'b1;
                    if (cfg_data == '0) begin
                        width_next = WW'(1);
                    end else if (32'(cfg_data) > MAX_WIDTH) begin
                        width_next = WW'(MAX_WIDTH);
                    end else begin
                        width_next = WW'(cfg_data);
                    end
                end
                CFG_IMAGE_HEIGHT: begin
                    restart = 1'b1;
                    if (cfg_data == '0) begin
                        height_next = HW'(1);
                    end else if (32'(cfg_data) > MAX_HEIGHT) begin
                        height_next = HW'(MAX_HEIGHT);
                    end else begin
                        height_next = HW'(cfg_data);
                    end
                end
                CFG_CHANNEL_THRESHOLD: ch_thr_next  = cfg_data[7:0];
                CFG_SUM_THRESHOLD:     sum_thr_next = cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= W_RESET;
            height_reg  <= H_RESET;
            ch_thr_reg  <= CH_THR_RESET;
            sum_thr_reg <= SUM_THR_RESET;
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            ch_thr_reg  <= ch_thr_next;
            sum_thr_reg <= sum_thr_next;
        end
    end

    cae_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (restart),
        .width     (width_reg),
        .height    (height_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .win_valid (win_valid),
        .win_ready (win_ready),
        .win       (win)
    );

    cae_filter u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ch_thr    (ch_thr_reg),
        .sum_thr   (sum_thr_reg),
        .win_valid (win_valid),
        .win_ready (win_ready),
        .win       (win),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: design/cae_window.sv
// Position counters, two line delay memories and the five-pixel window register.
// Depends on cae_pkg; feeds cae_filter.
module cae_window import cae_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              restart,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   height,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  s_item_t                           s_data,
    output logic                              win_valid,
    input  logic                              win_ready,
    output win_t                              win
);

    localparam int PW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    pixel_t line_a [MAX_WIDTH];
    pixel_t line_b [MAX_WIDTH];

    logic [PW-1:0] ptr_reg, ptr_next;
    logic [PW-1:0] in_col_reg, in_col_next;
    logic [HW-1:0] in_row_reg, in_row_next;
    logic [PW-1:0] out_col_reg, out_col_next;
    logic [HW-1:0] out_row_reg, out_row_next;
    logic          pad_reg, pad_next;
    logic          win_valid_reg, win_valid_next;

    pixel_t new_reg, bottom_reg, right_reg, center_reg, left_reg, top_reg;
    logic   has_left_reg, has_right_reg, has_top_reg, has_bottom_reg, done_reg;

    logic [WW-1:0] w_m1;
    logic [HW-1:0] h_m1;
    logic          push_ok, accept, in_full, in_lin_ge;
    logic          pix_push, drain_emit, pad_push, push, emit;
    logic          out_last_col, out_last_row, in_last_col;
    pixel_t        px;

    assign w_m1    = width - WW'(1);
    assign h_m1    = height - HW'(1);
    assign push_ok = !win_valid_reg || win_ready;
    assign s_ready = push_ok && !pad_reg;
    assign accept  = s_valid && s_ready;
    assign in_full = (in_row_reg == height);
    assign in_lin_ge = (in_row_reg > HW'(1)) || (in_row_reg == HW'(1) && in_col_reg != '0);

    assign pix_push   = accept && (s_data.action == ACTION_PIXEL) && !in_full;
    assign drain_emit = accept && (s_data.action == ACTION_DRAIN) && in_full;
    assign pad_push   = pad_reg && push_ok;
    assign push       = pix_push || drain_emit || pad_push;
    assign emit       = drain_emit || (pix_push && in_lin_ge);

    assign in_last_col  = (WW'(in_col_reg) == w_m1);
    assign out_last_col = (WW'(out_col_reg) == w_m1);
    assign out_last_row = (out_row_reg == h_m1);

    assign px = {s_data.in_alpha, s_data.in_blue, s_data.in_green, s_data.in_red};

    always_comb begin
        ptr_next       = ptr_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        pad_next       = pad_reg;
        win_valid_next = win_valid_reg;

        if (push_ok) begin
            win_valid_next = emit;
        end
        if (push) begin
            ptr_next = (WW'(ptr_reg) == w_m1) ? '0 : ptr_reg + PW'(1);
        end
        if (pad_push) begin
            pad_next = 1'b0;
        end
        if (pix_push) begin
            if (in_last_col) begin
                in_col_next = '0;
                in_row_next = in_row_reg + HW'(1);
                if (height == HW'(1)) begin
                    pad_next = 1'b1;
                end
            end else begin
                in_col_next = in_col_reg + PW'(1);
            end
        end
        if (emit) begin
            if (out_last_col && out_last_row) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else if (out_last_col) begin
                out_col_next = '0;
                out_row_next = out_row_reg + HW'(1);
            end else begin
                out_col_next = out_col_reg + PW'(1);
            end
        end
        if (restart) begin
            ptr_next     = '0;
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            pad_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg       <= '0;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            pad_reg       <= 1'b0;
            win_valid_reg <= 1'b0;
        end else begin
            ptr_reg       <= ptr_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            pad_reg       <= pad_next;
            win_valid_reg <= win_valid_next;
        end
    end

    // right tap is one line behind the newest pixel, top tap one line behind center
    always_ff @(posedge aclk) begin
        if (push) begin
            right_reg      <= line_a[ptr_reg];
            line_a[ptr_reg] <= px;
            top_reg        <= line_b[ptr_reg];
            line_b[ptr_reg] <= right_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            new_reg        <= px;
            bottom_reg     <= new_reg;
            center_reg     <= right_reg;
            left_reg       <= center_reg;
            has_left_reg   <= (out_col_reg != '0);
            has_right_reg  <= !out_last_col;
            has_top_reg    <= (out_row_reg != '0);
            has_bottom_reg <= !out_last_row;
            done_reg       <= out_last_col && out_last_row;
        end
    end

    assign win_valid      = win_valid_reg;
    assign win.center     = center_reg;
    assign win.left       = left_reg;
    assign win.right      = right_reg;
    assign win.top        = top_reg;
    assign win.bottom     = bottom_reg;
    assign win.has_left   = has_left_reg;
    assign win.has_right  = has_right_reg;
    assign win.has_top    = has_top_reg;
    assign win.has_bottom = has_bottom_reg;
    assign win.frame_done = done_reg;

endmodule

// File: design/cae_filter.sv
// Cross average, threshold decision and the result register.
// Depends on cae_pkg; takes windows from cae_window.
module cae_filter import cae_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] ch_thr,
    input  logic [9:0] sum_thr,
    input  logic       win_valid,
    output logic       win_ready,
    input  win_t       win,
    output logic       m_valid,
    input  logic       m_ready,
    output m_item_t    m_data
);

    logic    m_valid_reg, m_valid_next;
    m_item_t m_data_reg;
    pixel_t  result;

    always_comb begin
        pixel_t      l_sel, r_sel, t_sel, b_sel, avg;
        logic [10:0] s;
        logic [7:0]  d;
        logic [9:0]  sumd;
        logic        take;

        l_sel = win.has_left   ? win.left   : win.center;
        r_sel = win.has_right  ? win.right  : win.center;
        t_sel = win.has_top    ? win.top    : win.center;
        b_sel = win.has_bottom ? win.bottom : win.center;
        sumd  = '0;
        take  = 1'b0;
        avg   = '0;
        for (int k = 0; k < 4; k++) begin
            s = 11'(win.center[k]) + 11'(l_sel[k]) + 11'(r_sel[k])
              + 11'(t_sel[k]) + 11'(b_sel[k]);
            avg[k] = div5(s);
        end
        for (int k = 0; k < 3; k++) begin
            d = (avg[k] > win.center[k]) ? avg[k] - win.center[k]
                                         : win.center[k] - avg[k];
            if (d > ch_thr) begin
                take = 1'b1;
            end
            sumd = sumd + 10'(d);
        end
        if (sumd > sum_thr) begin
            take = 1'b1;
        end
        result = take ? avg : win.center;
    end

    assign win_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (win_ready) begin
            m_valid_next = win_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (win_valid && win_ready) begin
            m_data_reg.out_red    <= result[0];
            m_data_reg.out_green  <= result[1];
            m_data_reg.out_blue   <= result[2];
            m_data_reg.out_alpha  <= result[3];
            m_data_reg.frame_done <= win.frame_done;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: design/cae_checker.sv
// Port-level checks of the cross average filter, bound to the top level.
// Depends on cae_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cae_checker import cae_pkg::*; (
    input logic    aclk,
    input logic    aresetn,
    input logic    m_valid,
    input logic    m_ready,
    input m_item_t m_data
);

    `CAE_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped while stalled")
    `CAE_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_valid && !m_ready, $stable(m_data), "result changed while stalled")
    `CAE_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid, "result valid after reset")
    `CAE_ASSERT_NEXT_ALWAYS(a_first_cycle, aclk, $rose(aresetn), !m_valid, "result too soon after reset")

endmodule

bind cross_average_edge_antialias cae_checker u_cae_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: tb/cross_filter_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the five-point cross average filter: line store, positions and filter math.
// Depends on cae_pkg for the transaction structs, register indexes and reset values.
package cross_filter_scoreboard_pkg;
    import cae_pkg::*;

    class cross_filter_scoreboard;
        localparam int LINE_MAX   = 1024;
        localparam int ROWS_MAX   = 1024;
        localparam int RING_DEPTH = 2 * LINE_MAX + 2;

        int unsigned width;
        int unsigned height;
        int unsigned chan_limit;
        int unsigned sum_limit;
        int unsigned in_col;
        int unsigned in_row;
        int unsigned out_col;
        int unsigned out_row;
        pixel_t      ring [RING_DEPTH];
        m_item_t     expected_pixels [$];
        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned averaged;
        int unsigned passed_through;
        int unsigned frames_done;

        function new();
            width      = LINE_MAX;
            height     = ROWS_MAX;
            chan_limit = CH_THR_RESET;
            sum_limit  = SUM_THR_RESET;
            restart();
        endfunction

        function void restart();
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void configure(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            int unsigned v;
            v = value;
            case (idx)
                CFG_IMAGE_WIDTH: begin
                    width = (v == 0) ? 1 : ((v > LINE_MAX) ? LINE_MAX : v);
                    restart();
                end
                CFG_IMAGE_HEIGHT: begin
                    height = (v == 0) ? 1 : ((v > ROWS_MAX) ? ROWS_MAX : v);
                    restart();
                end
                CFG_CHANNEL_THRESHOLD: chan_limit = v & 'hFF;
                CFG_SUM_THRESHOLD:     sum_limit = v & 'h3FF;
                default: ;
            endcase
        endfunction

        function void filter_next_pixel();
            int unsigned lin;
            int unsigned s;
            int unsigned d;
            int unsigned sum_diff;
            pixel_t      ctr;
            pixel_t      avg;
            pixel_t      nbr [4];
            bit          replace;
            m_item_t     res;
            lin      = out_row * width + out_col;
            ctr      = ring[lin % RING_DEPTH];
            nbr[0]   = (out_col + 1 < width) ? ring[(lin + 1) % RING_DEPTH] : ctr;
            nbr[1]   = (out_col > 0) ? ring[(lin - 1) % RING_DEPTH] : ctr;
            nbr[2]   = (out_row + 1 < height) ? ring[(lin + width) % RING_DEPTH] : ctr;
            nbr[3]   = (out_row > 0) ? ring[(lin - width) % RING_DEPTH] : ctr;
            sum_diff = 0;
            replace  = 1'b0;
            for (int k = 0; k < 4; k++) begin
                s = ctr[k];
                for (int n = 0; n < 4; n++) s += nbr[n][k];
                avg[k] = 8'(s / 5);
            end
            for (int k = 0; k < 3; k++) begin
                d = (avg[k] > ctr[k]) ? avg[k] - ctr[k] : ctr[k] - avg[k];
                if (d > chan_limit) replace = 1'b1;
                sum_diff += d;
            end
            if (sum_diff > sum_limit) replace = 1'b1;
            if (replace) averaged++;
            else passed_through++;
            res.out_red   = replace ? avg[0] : ctr[0];
            res.out_green = replace ? avg[1] : ctr[1];
            res.out_blue  = replace ? avg[2] : ctr[2];
            res.out_alpha = replace ? avg[3] : ctr[3];
            if (lin + 1 == width * height) begin
                res.frame_done = 1'b1;
                frames_done++;
                restart();
            end else begin
                res.frame_done = 1'b0;
                out_col++;
                if (out_col >= width) begin
                    out_col = 0;
                    out_row++;
                end
            end
            expected_pixels.push_back(res);
        endfunction

        function void note_input(s_item_t item);
            int unsigned total;
            int unsigned in_lin;
            int unsigned out_lin;
            total   = width * height;
            in_lin  = in_row * width + in_col;
            out_lin = out_row * width + out_col;
            if (item.action == ACTION_PIXEL) begin
                if (in_lin >= total) return;
                ring[in_lin % RING_DEPTH] =
                    {item.in_alpha, item.in_blue, item.in_green, item.in_red};
                in_col++;
                if (in_col >= width) begin
                    in_col = 0;
                    in_row++;
                end
                if (in_lin >= width + 1) filter_next_pixel();
            end else if (in_lin >= total && out_lin < total) begin
                filter_next_pixel();
            end
        endfunction

        task report(string what);
            $display("MISMATCH at %0t, result %0d: %s", $time, results_seen, what);
            mismatches++;
        endtask

        task check_result(m_item_t got);
            m_item_t want;
            results_seen++;
            if (expected_pixels.size() == 0) begin
                report($sformatf("unexpected transaction %h", got));
                return;
            end
            want = expected_pixels.pop_front();
            if (got.out_red !== want.out_red)
                report($sformatf("red %0d, expected %0d", got.out_red, want.out_red));
            if (got.out_green !== want.out_green)
                report($sformatf("green %0d, expected %0d", got.out_green, want.out_green));
            if (got.out_blue !== want.out_blue)
                report($sformatf("blue %0d, expected %0d", got.out_blue, want.out_blue));
            if (got.out_alpha !== want.out_alpha)
                report($sformatf("alpha %0d, expected %0d", got.out_alpha, want.out_alpha));
            if (got.frame_done !== want.frame_done)
                report($sformatf("frame_done %b, expected %b", got.frame_done,
                                 want.frame_done));
        endtask
    endclass

endpackage

// File: tb/tb.sv
`timescale 1ns / 100ps
// Top-level testbench of cross_average_edge_antialias: clock, reset, drivers and phases.
// Depends on cae_pkg and cross_filter_scoreboard_pkg.
module tb;
    import cae_pkg::*;
    import cross_filter_scoreboard_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 500;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 80;
    localparam int unsigned WIDE_CAP      = 1100;
    localparam int unsigned NO_CAP        = 32'hFFFF_FFFF;
    localparam int unsigned TIMEOUT_NS    = 20_000_000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    s_item_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    m_item_t               m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cross_filter_scoreboard sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned hold_req      = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned frame_no      = 0;
    int unsigned random_items  = 0;

    cross_average_edge_antialias DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    function automatic pixel_t make_pixel(int unsigned style, pixel_t base);
        pixel_t px;
        int     v;
        for (int k = 0; k < 4; k++) begin
            case (style)
                0: px[k] = 8'($urandom);
                1: begin
                    v = int'(base[k]) + int'($urandom_range(16)) - 8;
                    px[k] = (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : 8'(v));
                end
                2: px[k] = $urandom_range(1) ? 8'hFF : 8'h00;
                default: px[k] = ($urandom_range(7) == 0) ? 8'($urandom) : base[k];
            endcase
        end
        return px;
    endfunction

    task automatic send_item(logic action, pixel_t px);
        s_item_t item;
        item.action   = action;
        item.in_red   = px[0];
        item.in_green = px[1];
        item.in_blue  = px[2];
        item.in_alpha = px[3];
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(item);
    endtask

    // drop valid, hold until every expected transaction is out, then wait the given extra time
    task automatic wait_idle(int unsigned extra);
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.configure(idx, value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_frame(logic [CFG_DATA_W-1:0] w_raw, logic [CFG_DATA_W-1:0] h_raw,
                             bit may_break, int unsigned cap,
                             output int unsigned done);
        int unsigned           w;
        int unsigned           h;
        int unsigned           total;
        int unsigned           stop_at;
        int unsigned           mid;
        int unsigned           drains;
        int unsigned           style;
        logic [CFG_DATA_W-1:0] ch;
        logic [CFG_DATA_W-1:0] sum;
        pixel_t                base;
        frame_no++;
        wait_idle(SETTLE_CYCLES);
        case (frame_no % 5)
            1:       begin send_idle_pct = 54; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 54; end
            3:       begin send_idle_pct = 12; stall_pct = 12; end
            default: begin send_idle_pct = 0;  stall_pct = 0;  end
        endcase
        case ($urandom_range(4))
            0:       ch = '0;
            1:       ch = CFG_DATA_W'(255);
            2:       ch = CFG_DATA_W'($urandom_range(2047));
            default: ch = CFG_DATA_W'($urandom_range(40));
        endcase
        case ($urandom_range(4))
            0:       sum = '0;
            1:       sum = CFG_DATA_W'(1023);
            2:       sum = CFG_DATA_W'($urandom_range(2047));
            default: sum = CFG_DATA_W'($urandom_range(150));
        endcase
        write_reg(CFG_IMAGE_WIDTH, w_raw);
        write_reg(CFG_IMAGE_HEIGHT, h_raw);
        write_reg(CFG_CHANNEL_THRESHOLD, ch);
        write_reg(CFG_SUM_THRESHOLD, sum);
        w       = sb.width;
        h       = sb.height;
        total   = w * h;
        stop_at = (may_break && $urandom_range(9) == 0) ? $urandom_range(total - 1) : total;
        if (cap < stop_at) stop_at = cap;
        mid     = stop_at - stop_at / 4;
        style   = $urandom_range(3);
        base    = make_pixel(0, '0);
        for (int unsigned k = 0; k < stop_at; k++) begin
            if ($urandom_range(24) == 0) send_item(ACTION_DRAIN, make_pixel(0, base));
            if (k == mid && frame_no % 5 == 1) wait_idle(0);
            if (k == mid && frame_no % 5 == 2) hold_req++;
            send_item(ACTION_PIXEL, make_pixel(style, base));
        end
        if (stop_at < total) begin
            done = stop_at;
            return;
        end
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(3, 1)) send_item(ACTION_PIXEL, make_pixel(0, base));
        drains = (total < w + 1) ? total : w + 1;
        repeat (drains) send_item(ACTION_DRAIN, make_pixel(0, base));
        if ($urandom_range(3) == 0) send_item(ACTION_DRAIN, make_pixel(0, base));
        done = total + drains;
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d transactions still expected", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int unsigned w;
        int unsigned h;
        int unsigned n;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data  = '0;
        aresetn   = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // 3x2 frame, zero thresholds, corner values and misplaced transactions
        write_reg(CFG_IMAGE_WIDTH, 11'd3);
        write_reg(CFG_IMAGE_HEIGHT, 11'd2);
        write_reg(CFG_CHANNEL_THRESHOLD, 11'd0);
        write_reg(CFG_SUM_THRESHOLD, 11'd0);
        send_item(ACTION_DRAIN, 32'hFFFF_FFFF);
        send_item(ACTION_PIXEL, 32'h0000_0000);
        send_item(ACTION_PIXEL, 32'hFFFF_FFFF);
        send_item(ACTION_PIXEL, 32'hFF00_FF00);
        send_item(ACTION_DRAIN, 32'h0000_0000);
        send_item(ACTION_PIXEL, 32'h00FF_00FF);
        send_item(ACTION_PIXEL, 32'hFFFF_FFFF);
        send_item(ACTION_PIXEL, 32'h0000_0000);
        send_item(ACTION_PIXEL, 32'h5AA5_C33C);
        repeat (4) send_item(ACTION_DRAIN, 32'hA55A_3CC3);
        send_item(ACTION_DRAIN, 32'h0000_0000);

        // thresholds that never fire, width clamped up to a single pixel frame
        wait_idle(SETTLE_CYCLES);
        write_reg(CFG_CHANNEL_THRESHOLD, 11'd255);
        write_reg(CFG_SUM_THRESHOLD, 11'd1023);
        write_reg(CFG_IMAGE_WIDTH, 11'd0);
        write_reg(CFG_IMAGE_HEIGHT, 11'd1);
        send_item(ACTION_PIXEL, 32'h80FF_0011);
        send_item(ACTION_PIXEL, 32'h7F00_FFEE);
        send_item(ACTION_DRAIN, 32'h0000_0000);
        send_item(ACTION_DRAIN, 32'hFFFF_FFFF);

        // widest line with both sizes clamped, cut short; then a mid-size frame
        run_frame(11'd2047, 11'd2047, 1'b0, WIDE_CAP, n);
        run_frame(11'd40, 11'd6, 1'b0, NO_CAP, n);

        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(19))
                0:       begin w = 1; h = $urandom_range(8, 1); end
                1:       begin w = $urandom_range(24, 1); h = 1; end
                2:       begin w = $urandom_range(40, 20); h = $urandom_range(4, 2); end
                default: begin w = $urandom_range(8, 1); h = $urandom_range(8, 1); end
            endcase
            run_frame(CFG_DATA_W'(w), CFG_DATA_W'(h), 1'b1, NO_CAP, n);
            random_items += n;
        end

        wait_idle(20);
        $display("%0d frame setups, %0d random transactions; %0d frames completed",
                 frame_no, random_items, sb.frames_done);
        $display("%0d results checked: %0d averaged, %0d passed through",
                 sb.results_seen, sb.averaged, sb.passed_through);
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
